[rtl/core/xsr_pkg.sv]
// ----------------------------------------------------------------------------
// xsr_pkg
// Shared constants, codes, types and the generator step for the xorshift128+
// random source.
// ----------------------------------------------------------------------------
package xsr_pkg;

   localparam logic [63:0] SEED_FIRST_RESET  = 64'h853c49e6748fea9b;
   localparam logic [63:0] SEED_SECOND_RESET = 64'hda3e39cb94b95bdb;
   localparam logic [63:0] SEED_MIX          = 64'h6a09e667bb67ae85;

   localparam int unsigned SHIFT_A = 23;
   localparam int unsigned SHIFT_B = 18;
   localparam int unsigned SHIFT_C = 5;

   // dividend bits of the range reduction, one per divide cycle
   localparam int unsigned DIV_BITS  = 32;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);

   // unit double: 53-bit mantissa source, exponent field when bit 52 is set
   localparam int unsigned MAN_W        = 53;
   localparam int unsigned NORM_COARSE  = 8;
   localparam logic [10:0] UNIT_EXP_TOP = 11'd1022;

   typedef logic [2:0] xsr_mode_type;

   localparam xsr_mode_type MODE_SEED  = 3'd0;
   localparam xsr_mode_type MODE_I64   = 3'd1;
   localparam xsr_mode_type MODE_I32   = 3'd2;
   localparam xsr_mode_type MODE_UNIT  = 3'd3;
   localparam xsr_mode_type MODE_RANGE = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEED_A,
      ST_SEED_B,
      ST_DIVIDE,
      ST_NORMALISE,
      ST_PUBLISH
   } xsr_state_type;

   typedef struct packed {
      logic capture;
      logic load_seed;
      logic step;
      logic draw;
      logic div_step;
      logic norm_step;
      logic publish;
   } xsr_cmd_type;

   typedef struct packed {
      xsr_mode_type mode;
      logic         range_empty;
      logic         div_last;
      logic         norm_done;
      logic         out_free;
   } xsr_status_type;

   // next value of the second generator word
   function automatic logic [63:0] xsr_next_second(input logic [63:0] a,
                                                   input logic [63:0] b);
      logic [63:0] t;
      t = a ^ (a << SHIFT_A);
      return t ^ b ^ (t >> SHIFT_B) ^ (b >> SHIFT_C);
   endfunction

endpackage

[rtl/core/xsr_if.sv]
// ----------------------------------------------------------------------------
// xsr_req_if / xsr_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface xsr_req_if
   import xsr_pkg::*;
   ();
   logic                valid;
   logic                ready;
   xsr_mode_type        mode;
   logic signed [31:0]  seed_value;
   logic signed [31:0]  range_low;
   logic signed [31:0]  range_high;

   modport source (output valid, mode, seed_value, range_low, range_high, input ready);
   modport sink   (input valid, mode, seed_value, range_low, range_high, output ready);
endinterface

interface xsr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;

   modport source (output valid, value, input ready);
   modport sink   (input valid, value, output ready);
endinterface

[rtl/core/xorshift128plus_random_source.sv]
// ----------------------------------------------------------------------------
// xorshift128plus_random_source
// xorshift128+ generator with seed, 64-bit, 32-bit, unit double and range
// operations.
// ----------------------------------------------------------------------------
// One item is worked on at a time; req ready is high only while the sequencer
// is idle, and a finished item waits in the result register without holding
// up the next request. Seed items step through SEED_A and SEED_B; 64-bit,
// 32-bit and empty range items go straight to publish; unit doubles pass
// through the mantissa normaliser, which shifts by 8 or by 1 per step; range
// items pass through the bit-serial remainder unit, over 32 dividend bits. A
// result is held while the previous one has not been taken. Seed items and unused mode codes give no result.
module xorshift128plus_random_source
   import xsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   xsr_req_if.sink     req_chan,
   xsr_rsp_if.source   rsp_chan
);

   xsr_cmd_type    cmd;
   xsr_status_type status;

   xsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   xsr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_chan.mode),
      .req_seed_value (req_chan.seed_value),
      .req_range_low  (req_chan.range_low),
      .req_range_high (req_chan.range_high),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_value      (rsp_chan.value)
   );

endmodule

[rtl/core/xsr_ctrl.sv]
// ----------------------------------------------------------------------------
// xsr_ctrl
// Sequencer: takes one item at a time, steps the datapath through seeding,
// drawing, range reduction or normalisation, then hands over the result, if any.
// ----------------------------------------------------------------------------
module xsr_ctrl
   import xsr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  xsr_status_type status,
   output xsr_cmd_type    cmd
);

   xsr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (status.mode)
               MODE_SEED:          state_in = ST_SEED_A;
               MODE_I64, MODE_I32: state_in = ST_PUBLISH;
               MODE_UNIT:          state_in = ST_NORMALISE;
               MODE_RANGE:         state_in = status.range_empty ? ST_PUBLISH : ST_DIVIDE;
               default:            state_in = ST_IDLE;
            endcase
         end
         ST_SEED_A:    state_in = ST_SEED_B;
         ST_SEED_B:    state_in = ST_IDLE;
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_PUBLISH;
         end
         ST_NORMALISE: begin
            if (status.norm_done) state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DISPATCH: begin
            case (status.mode)
               MODE_SEED:                     cmd.load_seed = 1'b1;
               MODE_I64, MODE_I32, MODE_UNIT: cmd.draw      = 1'b1;
               MODE_RANGE:                    cmd.draw      = !status.range_empty;
               default:                       cmd.draw      = 1'b0;
            endcase
         end
         ST_SEED_A, ST_SEED_B: cmd.step      = 1'b1;
         ST_DIVIDE:            cmd.div_step  = 1'b1;
         ST_NORMALISE:         cmd.norm_step = !status.norm_done;
         ST_PUBLISH:           cmd.publish   = status.out_free;
         default:              cmd           = '0;
      endcase
   end

endmodule

[rtl/core/xsr_dp.sv]
// ----------------------------------------------------------------------------
// xsr_dp
// Datapath: generator words, operand capture, bit-serial remainder unit,
// mantissa normaliser and the result register.
// ----------------------------------------------------------------------------
module xsr_dp
   import xsr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  xsr_cmd_type        cmd,
   output xsr_status_type     status,
   input  xsr_mode_type       req_mode,
   input  logic signed [31:0] req_seed_value,
   input  logic signed [31:0] req_range_low,
   input  logic signed [31:0] req_range_high,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [63:0]        rsp_value
);

   logic [63:0]        word_a_ff, word_a_in;
   logic [63:0]        word_b_ff, word_b_in;
   xsr_mode_type       mode_ff;
   logic [31:0]        seed_ff;
   logic signed [31:0] lo_ff, hi_ff;
   logic [63:0]        sum_ff;
   logic [31:0]        span_ff;
   logic [31:0]        dvd_ff, rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [MAN_W-1:0]   man_ff, man_in;
   logic [10:0]        exp_ff, exp_in;
   logic               rsp_valid_ff;
   logic [63:0]        rsp_value_ff, result;

   logic [63:0] sum_now;
   logic [63:0] seed_word;
   logic [32:0] rem_sh, rem_diff;
   logic [31:0] rng_sum;
   logic        range_empty, norm_done, out_free;

   assign sum_now   = word_a_ff + word_b_ff;
   assign seed_word = {32'd0, seed_ff};

   always_comb begin
      word_a_in = word_a_ff;
      word_b_in = word_b_ff;
      if (cmd.load_seed) begin
         word_a_in = seed_word;
         word_b_in = seed_word ^ SEED_MIX;
      end else if (cmd.step || cmd.draw) begin
         word_a_in = word_b_ff;
         word_b_in = xsr_next_second(word_a_ff, word_b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_a_ff <= SEED_FIRST_RESET;
         word_b_ff <= SEED_SECOND_RESET;
      end else begin
         word_a_ff <= word_a_in;
         word_b_ff <= word_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         seed_ff <= req_seed_value;
         lo_ff   <= req_range_low;
         hi_ff   <= req_range_high;
      end
   end

   // restoring remainder, one dividend bit a cycle
   assign rem_sh   = {rem_ff, dvd_ff[31]};
   assign rem_diff = rem_sh - {1'b0, span_ff};
   assign rem_in   = rem_diff[32] ? rem_sh[31:0] : rem_diff[31:0];

   // coarse shift by a byte while the top byte is clear, else by one
   always_comb begin
      if (man_ff[MAN_W-1 -: NORM_COARSE] == '0) begin
         man_in = man_ff << NORM_COARSE;
         exp_in = exp_ff - 11'(NORM_COARSE);
      end else begin
         man_in = man_ff << 1;
         exp_in = exp_ff - 11'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.draw) begin
         sum_ff  <= sum_now;
         span_ff <= hi_ff - lo_ff;
         dvd_ff  <= sum_now[63:32];
         rem_ff  <= '0;
         cnt_ff  <= '0;
         man_ff  <= sum_now[63 -: MAN_W];
         exp_ff  <= UNIT_EXP_TOP;
      end else begin
         if (cmd.div_step) begin
            rem_ff <= rem_in;
            dvd_ff <= dvd_ff << 1;
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.norm_step) begin
            man_ff <= man_in;
            exp_ff <= exp_in;
         end
      end
   end

   assign range_empty = hi_ff <= lo_ff;
   assign norm_done   = man_ff[MAN_W-1] || (man_ff == '0);
   assign rng_sum     = lo_ff + rem_ff;

   always_comb begin
      case (mode_ff)
         MODE_I64:   result = sum_ff;
         MODE_I32:   result = {{32{sum_ff[63]}}, sum_ff[63:32]};
         MODE_UNIT:  result = (man_ff == '0) ? 64'd0 : {1'b0, exp_ff, man_ff[MAN_W-2:0]};
         MODE_RANGE: result = range_empty ? {{32{lo_ff[31]}}, lo_ff}
                                          : {{32{rng_sum[31]}}, rng_sum};
         default:    result = '0;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) rsp_value_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   assign status.mode        = mode_ff;
   assign status.range_empty = range_empty;
   assign status.div_last    = cnt_ff == DIV_CNT_W'(DIV_BITS - 1);
   assign status.norm_done   = norm_done;
   assign status.out_free    = out_free;

endmodule

[rtl/core/xsr_checker.sv]
// ----------------------------------------------------------------------------
// xsr_checker
// Port-level checks on the random source, bound to the top level.
// ----------------------------------------------------------------------------
module xsr_checker
   import xsr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   xsr_req_if.sink   req_chan,
   xsr_rsp_if.source rsp_chan
);

   logic req_take, rsp_take;

   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;

   // leaving reset: idle and nothing pending
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (req_chan.ready && !rsp_chan.valid))
      else $error("not idle after reset");

   // one item at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_chan.ready)
      else $error("request taken while busy");

   // no item finishes in the cycle after it is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_take && (!rsp_chan.valid || rsp_chan.ready)) |=> !rsp_chan.valid)
      else $error("result appeared too early");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> (rsp_chan.valid && $stable(rsp_chan.value)))
      else $error("stalled result changed");

endmodule

bind xorshift128plus_random_source xsr_checker u_xsr_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
